// ===== hw/rtl/proximity_hold_cooldown_qualifier_macros.svh =====
// Assertion macros for the proximity hold qualifier.
// Used by the top level only; expects signals clk and rst in scope.
`ifndef PROXIMITY_HOLD_COOLDOWN_QUALIFIER_MACROS_SVH
`define PROXIMITY_HOLD_COOLDOWN_QUALIFIER_MACROS_SVH

// checked outside reset
`define PHCQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked in every cycle, reset included
`define PHCQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/phcq_pkg.sv =====
// Shared types and constants for the proximity hold qualifier.
// No dependencies.
`timescale 1ns / 1ps
package phcq_pkg;

  localparam int unsigned CFG_W  = 16;
  localparam int unsigned ECHO_W = 16;
  localparam int unsigned TIME_W = 32;

  // echo*343 <= threshold*20000 is the integer form of echo*0.0343/2 <= threshold
  localparam logic [8:0]  ECHO_SCALE   = 9'd343;
  localparam logic [14:0] THRESH_SCALE = 15'd20000;

  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd100;
  localparam logic [CFG_W-1:0] HOLD_RESET      = 16'd1000;
  localparam logic [CFG_W-1:0] MIN_OFF_RESET   = 16'd0;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_HOLD      = 2'd1,
    REG_MIN_OFF   = 2'd2
  } cfg_reg_t;

  // one qualified reading handed from the front stage to the core
  typedef struct packed {
    logic              near;
    logic [TIME_W-1:0] now_ms;
  } phcq_item_t;

endpackage

// ===== hw/rtl/proximity_hold_cooldown_qualifier.sv =====
// Proximity hold qualifier with re-arm cooldown: top level and config registers.
// Depends on phcq_pkg, phcq_front, phcq_core and the assertion macro header.
//
// One ultrasonic reading in, one result out. An item passes through the input
// register, where the near compare (two constant multiplies) is registered,
// and then the result register, which takes the updated hold/cooldown state.
// A new item is taken every cycle as long as results are drained; the core
// computes its next state from the registered state and the item without an
// extra register, so throughput is one item per clock. Config writes take effect at once and belong in idle periods.
`timescale 1ns / 1ps
`include "proximity_hold_cooldown_qualifier_macros.svh"
module proximity_hold_cooldown_qualifier (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [1:0]                 cfg_addr,
  input  logic [phcq_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [phcq_pkg::ECHO_W-1:0] echo_us,
  input  logic [phcq_pkg::TIME_W-1:0] now_ms,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       detected,
  output logic                       cooling_down
);
  import phcq_pkg::*;

  logic [CFG_W-1:0] near_limit_cm;
  logic [CFG_W-1:0] hold_ms;
  logic [CFG_W-1:0] min_off_ms;
  logic             item_valid;
  logic             item_ready;
  phcq_item_t       item;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit_cm <= THRESHOLD_RESET;
      hold_ms       <= HOLD_RESET;
      min_off_ms    <= MIN_OFF_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_THRESHOLD: near_limit_cm <= cfg_wdata;
        REG_HOLD:      hold_ms       <= cfg_wdata;
        REG_MIN_OFF:   min_off_ms    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  phcq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .echo_us       (echo_us),
    .now_ms        (now_ms),
    .near_limit_cm (near_limit_cm),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item)
  );

  phcq_core u_core (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .hold_ms      (hold_ms),
    .min_off_ms   (min_off_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .detected     (detected),
    .cooling_down (cooling_down)
  );

  `PHCQ_ASSERT_ALWAYS(a_no_result_after_reset, rst |=> !out_valid, "result valid after reset")
  `PHCQ_ASSERT(a_ready_when_drained, !out_valid |-> in_ready, "input stalled with empty output")
  `PHCQ_ASSERT(a_no_cool_without_min_off,
    out_valid && detected && (min_off_ms == '0) |-> !cooling_down,
    "cooldown reported with cooldown disabled")

endmodule

// ===== hw/rtl/phcq_front.sv =====
// Input register stage: accepts a reading and registers its near flag.
// Depends on phcq_pkg.
`timescale 1ns / 1ps
module phcq_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [phcq_pkg::ECHO_W-1:0] echo_us,
  input  logic [phcq_pkg::TIME_W-1:0] now_ms,
  input  logic [phcq_pkg::CFG_W-1:0]  near_limit_cm,
  output logic                      item_valid,
  input  logic                      item_ready,
  output phcq_pkg::phcq_item_t      item
);
  import phcq_pkg::*;

  logic [24:0] echo_scaled;
  logic [30:0] limit_scaled;
  logic        near;

  assign echo_scaled  = 25'(echo_us) * 25'(ECHO_SCALE);
  assign limit_scaled = 31'(near_limit_cm) * 31'(THRESH_SCALE);
  assign near         = (echo_us != '0) && ({6'd0, echo_scaled} <= limit_scaled);

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.near   <= near;
      item.now_ms <= now_ms;
    end
  end

endmodule

// ===== hw/rtl/phcq_core.sv =====
// Hold and cooldown state, decision logic and result register.
// Depends on phcq_pkg.
`timescale 1ns / 1ps
module phcq_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  phcq_pkg::phcq_item_t     item,
  input  logic [phcq_pkg::CFG_W-1:0] hold_ms,
  input  logic [phcq_pkg::CFG_W-1:0] min_off_ms,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     detected,
  output logic                     cooling_down
);
  import phcq_pkg::*;

  logic              near_active, near_active_next;
  logic [TIME_W-1:0] near_start_ms, near_start_ms_next;
  logic              in_cooldown, in_cooldown_next;
  logic              off_timing, off_timing_next;
  logic [TIME_W-1:0] off_start_ms, off_start_ms_next;
  logic              det_next;
  logic [TIME_W-1:0] near_elapsed, off_elapsed;
  logic              advance;

  assign item_ready = !out_valid || out_ready;
  assign advance    = item_valid && item_ready;

  assign near_elapsed = item.now_ms - near_start_ms;
  assign off_elapsed  = item.now_ms - off_start_ms;

  always_comb begin
    near_active_next   = near_active;
    near_start_ms_next = near_start_ms;
    in_cooldown_next   = in_cooldown;
    off_timing_next    = off_timing;
    off_start_ms_next  = off_start_ms;
    det_next           = 1'b0;

    if (in_cooldown) begin
      if (!item.near) begin
        if (!off_timing) begin
          // first clear reading only starts the off timer
          off_timing_next   = 1'b1;
          off_start_ms_next = item.now_ms;
        end else if (off_elapsed >= TIME_W'(min_off_ms)) begin
          in_cooldown_next  = 1'b0;
          off_timing_next   = 1'b0;
          off_start_ms_next = '0;
        end
      end else begin
        off_timing_next   = 1'b0;
        off_start_ms_next = '0;
      end
    end

    if (in_cooldown_next || !item.near) begin
      near_active_next   = 1'b0;
      near_start_ms_next = '0;
    end else if (!near_active) begin
      near_active_next   = 1'b1;
      near_start_ms_next = item.now_ms;
    end else if (near_elapsed >= TIME_W'(hold_ms)) begin
      det_next = 1'b1;
      if (min_off_ms != '0) begin
        in_cooldown_next  = 1'b1;
        off_timing_next   = 1'b0;
        off_start_ms_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      near_active   <= 1'b0;
      near_start_ms <= '0;
      in_cooldown   <= 1'b0;
      off_timing    <= 1'b0;
      off_start_ms  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        near_active   <= near_active_next;
        near_start_ms <= near_start_ms_next;
        in_cooldown   <= in_cooldown_next;
        off_timing    <= off_timing_next;
        off_start_ms  <= off_start_ms_next;
      end
      if (item_ready) begin
        out_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      detected     <= det_next;
      cooling_down <= in_cooldown_next;
    end
  end

endmodule
